FILE: hdl/small_block_first_fit_allocator_macros.svh
// assertion macros shared by the allocator modules
`ifndef SMALL_BLOCK_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define SMALL_BLOCK_FIRST_FIT_ALLOCATOR_MACROS_SVH

// property that holds on every clock edge outside reset
`define SBA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define SBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/sba_pkg.sv
`timescale 1ns / 1ps

package sba_pkg;

    // operation codes
    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DISABLED  = 3'd1;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
    localparam logic [2:0] ST_NO_SPACE  = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    // configuration register indexes
    localparam logic REG_ENABLE     = 1'b0;
    localparam logic REG_PAGE_LIMIT = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [10:0] req_size;
        logic [3:0]  page_slot;
        logic [11:0] byte_offset;
    } request_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  out_page;
        logic [11:0] out_offset;
        logic [10:0] out_size;
        logic [4:0]  pages_open;
    } result_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_ORD_RD,
        S_ORD_WAIT,
        S_HDR_RD,
        S_HDR_WAIT,
        S_HDR_EVAL,
        S_OPEN,
        S_SPLIT,
        S_LOC_RD,
        S_LOC_WAIT,
        S_LOC_EVAL,
        S_MARK_FREE,
        S_REL,
        S_REL_WAIT,
        S_REL_MOVE,
        S_MRG_RD,
        S_MRG_WAIT,
        S_MRG_EVAL,
        S_MRG_NRD,
        S_MRG_NWAIT,
        S_MRG_NEVAL,
        S_DONE
    } state_t;

    // controller commands to the datapath
    typedef struct packed {
        logic load_req;       // capture request, clear scratch
        logic ord_rd;         // read order list at index
        logic ord_take;       // take read order entry as page
        logic ord_next;       // advance order index
        logic hdr_rd_cur;     // read header at cursor
        logic hdr_rd_nxt;     // read header at cursor + span
        logic hdr_latch;      // capture header at cursor
        logic nxt_latch;      // capture neighbor header
        logic cur_advance;    // cursor += span
        logic cur_to_first;   // cursor to first block
        logic open_page;      // open lowest free slot
        logic split_wr;       // allocate block, split
        logic free_wr;        // mark block free, live count down
        logic merge_wr;       // grow block by neighbor span
        logic rel_start;      // start order list compaction
        logic rel_step;       // one step of compaction
        logic rel_finish;     // commit release
        logic set_status;     // record status code
        logic [2:0] status;
        logic set_found;      // record ok result
        logic emit;           // present result
    } cmd_t;

    // datapath status to the controller
    typedef struct packed {
        logic [1:0] op;
        logic size_bad;
        logic ord_more;       // index < order length
        logic hdr_bad;        // span zero or past end
        logic hdr_fit;        // free and big enough
        logic cur_end;        // cursor at or past end
        logic at_target;      // cursor equals target
        logic hdr_free;       // cursor block free
        logic nxt_end;        // neighbor position at end
        logic nxt_bad;        // neighbor header damaged
        logic nxt_free;       // neighbor block free
        logic can_open;       // page may open and fits
        logic loc_ok;         // slot open and offset legal
        logic live_last;      // live count will reach zero
        logic rel_more;       // compaction not done
    } stat_t;

endpackage

FILE: hdl/small_block_first_fit_allocator.sv
`timescale 1ns / 1ps
// First-fit allocator over page slots. A request is taken when start is high
// and busy is low; its result appears on result for exactly one cycle with
// result_valid high, and the receiver cannot stall it, so it must take the
// result in that cycle. Op code 3 gives no result. The header walk reads one
// header per step through the single read port of the header memory, so an
// allocate walks the headers of the open pages in order up to the first fit,
// and a free adds the merge walk, or an order list pass over the open pages
// when the page is released. No clearing pass.

module small_block_first_fit_allocator #(
    parameter int NUM_PAGES   = 16,
    parameter int PAGE_BYTES  = 4096,
    parameter int SMALL_LIMIT = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  sba_pkg::request_t  request,
    output logic               result_valid,
    output sba_pkg::result_t   result,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [4:0]         cfg_data
);

    sba_pkg::cmd_t  cmd;
    sba_pkg::stat_t stat;
    logic           enable_reg;

    // enable register; page limit lives in the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            enable_reg <= 1'b0;
        else if (cfg_we && cfg_index == sba_pkg::REG_ENABLE)
            enable_reg <= cfg_data[0];
    end

    sba_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .enable (enable_reg),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    sba_datapath #(
        .NUM_PAGES   (NUM_PAGES),
        .PAGE_BYTES  (PAGE_BYTES),
        .SMALL_LIMIT (SMALL_LIMIT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_limit_we (cfg_we && cfg_index == sba_pkg::REG_PAGE_LIMIT),
        .cfg_limit    (cfg_data),
        .req          (request),
        .cmd          (cmd),
        .stat         (stat),
        .res          (result),
        .res_valid    (result_valid)
    );

endmodule

FILE: hdl/sba_datapath.sv
`timescale 1ns / 1ps
`include "small_block_first_fit_allocator_macros.svh"

module sba_datapath #(
    parameter int NUM_PAGES   = 16,
    parameter int PAGE_BYTES  = 4096,
    parameter int SMALL_LIMIT = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_limit_we,
    input  logic [4:0]         cfg_limit,
    input  sba_pkg::request_t  req,
    input  sba_pkg::cmd_t      cmd,
    output sba_pkg::stat_t     stat,
    output sba_pkg::result_t   res,
    output logic               res_valid
);

    localparam int UNITS   = PAGE_BYTES / 8;
    localparam int UW      = $clog2(UNITS + 1);
    localparam int PW      = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int CW      = $clog2(NUM_PAGES + 1);
    localparam int AW      = PW + $clog2(UNITS);
    localparam int HDR     = 4;
    localparam int SW      = 11;

    // header memories, one entry per 8-byte position
    logic [UW-1:0] span_mem [NUM_PAGES*UNITS];
    logic [SW-1:0] rq_mem   [NUM_PAGES*UNITS];
    logic [PW-1:0] order_mem [NUM_PAGES];

    logic [8:0]           live_reg [NUM_PAGES];
    logic [NUM_PAGES-1:0] in_use_reg;
    logic [CW-1:0]        olen_reg;
    logic [4:0]           limit_reg;

    sba_pkg::request_t req_reg;
    logic [UW-1:0]  need_reg;
    logic [PW-1:0]  page_reg;
    logic [UW-1:0]  cur_reg;
    logic [UW-1:0]  span_reg;
    logic [SW-1:0]  rq_reg;
    logic [UW-1:0]  nspan_reg;
    logic [SW-1:0]  nrq_reg;
    logic [CW-1:0]  idx_reg;
    logic [CW-1:0]  wj_reg;
    logic [UW-1:0]  target_reg;
    sba_pkg::result_t res_reg;
    logic           res_valid_reg;

    // memory read ports
    logic          rd_en, rd_sel_nxt;
    logic [AW-1:0] rd_addr;
    logic [UW-1:0] span_q;
    logic [SW-1:0] rq_q;
    logic [PW-1:0] ord_q;

    // memory write port
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [UW-1:0] wr_span;
    logic [SW-1:0] wr_rq;
    logic          wr_span_en;

    logic [UW:0]   nxt_pos;
    logic [UW:0]   split_pos;
    logic [PW-1:0] free_slot;
    logic          free_found;
    logic [4:0]    lim_eff;
    logic          ord_wr;
    logic [CW-1:0] ord_wr_idx;
    logic [PW-1:0] ord_wr_val;

    function automatic logic [AW-1:0] addr_of(input logic [PW-1:0] p, input logic [UW-1:0] u);
        logic [AW:0] a;
        a = (AW+1)'(p) * (AW+1)'(UNITS) + (AW+1)'(u);
        return a[AW-1:0];
    endfunction

    assign nxt_pos   = (UW+1)'(cur_reg) + (UW+1)'(span_reg);
    assign split_pos = (UW+1)'(cur_reg) + (UW+1)'(need_reg);
    assign lim_eff   = (32'(limit_reg) > NUM_PAGES) ? 5'(NUM_PAGES) : limit_reg;

    // lowest free page slot
    always_comb
    begin
        free_slot  = '0;
        free_found = 1'b0;
        for (int i = NUM_PAGES - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_slot  = PW'(i);
                free_found = 1'b1;
            end
        end
    end

    // read address select
    always_comb
    begin
        rd_en      = cmd.hdr_rd_cur | cmd.hdr_rd_nxt;
        rd_sel_nxt = cmd.hdr_rd_nxt;
        rd_addr    = rd_sel_nxt ? addr_of(page_reg, nxt_pos[UW-1:0])
                                : addr_of(page_reg, cur_reg);
    end

    // write port select
    always_comb
    begin
        wr_en      = 1'b0;
        wr_span_en = 1'b0;
        wr_addr    = addr_of(page_reg, cur_reg);
        wr_span    = span_reg;
        wr_rq      = '0;
        if (cmd.open_page)
        begin
            wr_en      = free_found;
            wr_span_en = 1'b1;
            wr_addr    = addr_of(free_slot, UW'(HDR));
            wr_span    = UW'(UNITS - HDR);
        end
        else if (cmd.split_wr)
        begin
            // remainder header when two or more units remain, else the block; the second pass writes the block
            wr_en      = 1'b1;
            wr_span_en = 1'b1;
            if (span_reg - need_reg >= UW'(2))
            begin
                wr_addr = addr_of(page_reg, split_pos[UW-1:0]);
                wr_span = span_reg - need_reg;
                wr_rq   = '0;
            end
            else
            begin
                wr_addr = addr_of(page_reg, cur_reg);
                wr_span = span_reg;
                wr_rq   = req_reg.req_size;
            end
        end
        else if (cmd.free_wr)
        begin
            wr_en      = 1'b1;
            wr_span_en = 1'b1;
            wr_span    = span_reg;
            wr_rq      = '0;
        end
        else if (cmd.merge_wr)
        begin
            wr_en      = 1'b1;
            wr_span_en = 1'b1;
            wr_span    = span_reg + nspan_reg;
            wr_rq      = '0;
        end
    end

    // header memories
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            if (wr_span_en)
                span_mem[wr_addr] <= wr_span;
            rq_mem[wr_addr] <= wr_rq;
        end
        if (rd_en)
        begin
            span_q <= span_mem[rd_addr];
            rq_q   <= rq_mem[rd_addr];
        end
    end

    // order list write select
    always_comb
    begin
        ord_wr     = 1'b0;
        ord_wr_idx = olen_reg;
        ord_wr_val = free_slot;
        if (cmd.open_page && free_found)
            ord_wr = 1'b1;
        else if (cmd.rel_step && ord_q != req_reg.page_slot[PW-1:0])
        begin
            ord_wr     = 1'b1;
            ord_wr_idx = wj_reg;
            ord_wr_val = ord_q;
        end
    end

    // order list memory
    always_ff @(posedge clk)
    begin
        if (ord_wr)
            order_mem[ord_wr_idx[PW-1:0]] <= ord_wr_val;
        if (cmd.ord_rd)
            ord_q <= order_mem[idx_reg[PW-1:0]];
    end

    // control state: page table, counts and limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg    <= '0;
            olen_reg      <= '0;
            limit_reg     <= 5'd16;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_PAGES; i++)
                live_reg[i] <= '0;
        end
        else
        begin
            res_valid_reg <= cmd.emit;
            if (cfg_limit_we)
                limit_reg <= cfg_limit;
            if (cmd.open_page && free_found)
            begin
                in_use_reg[free_slot] <= 1'b1;
                live_reg[free_slot]   <= '0;
                olen_reg              <= olen_reg + CW'(1);
            end
            if (cmd.set_found && req_reg.op == sba_pkg::OP_ALLOC)
                live_reg[page_reg] <= live_reg[page_reg] + 9'd1;
            if (cmd.free_wr)
                live_reg[page_reg] <= live_reg[page_reg] - 9'd1;
            if (cmd.rel_finish)
            begin
                olen_reg              <= wj_reg;
                in_use_reg[page_reg]  <= 1'b0;
                live_reg[page_reg]    <= '0;
            end
        end
    end

    // request scratch registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg    <= req;
            need_reg   <= UW'((12'(req.req_size) + 12'd7) >> 3) + UW'(1);
            idx_reg    <= '0;
            page_reg   <= req.page_slot[PW-1:0];
            target_reg <= UW'(req.byte_offset >> 3) - UW'(1);
            res_reg    <= '0;
        end
        if (cmd.ord_take)
            page_reg <= ord_q;
        if (cmd.ord_next)
            idx_reg <= idx_reg + CW'(1);
        if (cmd.open_page)
            page_reg <= free_slot;
        if (cmd.cur_to_first)
            cur_reg <= UW'(HDR);
        if (cmd.cur_advance)
            cur_reg <= nxt_pos[UW-1:0];
        if (cmd.hdr_latch)
        begin
            span_reg <= span_q;
            rq_reg   <= rq_q;
        end
        if (cmd.nxt_latch)
        begin
            nspan_reg <= span_q;
            nrq_reg   <= rq_q;
        end
        if (cmd.merge_wr)
            span_reg <= span_reg + nspan_reg;
        if (cmd.split_wr && span_reg - need_reg >= UW'(2))
            span_reg <= need_reg;
        if (cmd.rel_start)
        begin
            idx_reg <= '0;
            wj_reg  <= '0;
        end
        if (cmd.rel_step)
        begin
            idx_reg <= idx_reg + CW'(1);
            if (ord_q != req_reg.page_slot[PW-1:0])
                wj_reg <= wj_reg + CW'(1);
        end
        if (cmd.set_status)
            res_reg.status <= cmd.status;
        if (cmd.set_found)
        begin
            res_reg.status <= sba_pkg::ST_OK;
            if (req_reg.op == sba_pkg::OP_ALLOC)
            begin
                res_reg.out_page   <= 4'(page_reg);
                res_reg.out_offset <= 12'((32'(cur_reg) + 1) * 8);
                res_reg.out_size   <= req_reg.req_size;
            end
            else
                res_reg.out_size <= rq_reg;
        end
    end

    // status toward the controller
    always_comb
    begin
        stat.op          = req_reg.op;
        stat.size_bad    = (req_reg.req_size == '0) || (32'(req_reg.req_size) > SMALL_LIMIT);
        stat.ord_more    = (idx_reg < olen_reg) && (32'(idx_reg) < NUM_PAGES);
        stat.hdr_bad     = (span_reg == '0) || (32'(span_reg) > UNITS - 32'(cur_reg));
        stat.hdr_fit     = (rq_reg == '0) && (span_reg >= need_reg);
        stat.cur_end     = 32'(cur_reg) >= UNITS;
        stat.at_target   = cur_reg == target_reg;
        stat.hdr_free    = rq_reg == '0;
        stat.nxt_end     = 32'(nxt_pos) >= UNITS;
        stat.nxt_bad     = (nspan_reg == '0) || (32'(nspan_reg) > UNITS - 32'(nxt_pos));
        stat.nxt_free    = nrq_reg == '0;
        stat.can_open    = (32'(olen_reg) < 32'(lim_eff)) && free_found
                           && (32'(need_reg) <= UNITS - HDR);
        stat.loc_ok      = (32'(req_reg.page_slot) < NUM_PAGES)
                           && in_use_reg[req_reg.page_slot[PW-1:0]]
                           && (req_reg.byte_offset[2:0] == 3'd0)
                           && (req_reg.byte_offset >= 12'd8)
                           && (32'(req_reg.byte_offset >> 3) - 1 < UNITS);
        stat.live_last   = live_reg[page_reg] == 9'd1;
        stat.rel_more    = (idx_reg < olen_reg) && (32'(idx_reg) < NUM_PAGES);
    end

    // result with the page count after the request
    always_comb
    begin
        res            = res_reg;
        res.pages_open = 5'(olen_reg);
    end
    assign res_valid = res_valid_reg;

    `SBA_ASSERT(a_olen_max, clk, rst_n, 32'(olen_reg) <= NUM_PAGES,
        "order length exceeds page count")
    `SBA_ASSERT(a_olen_count, clk, rst_n, 32'(olen_reg) == $countones(in_use_reg),
        "order length disagrees with page table")
    `SBA_ASSERT_NEXT(a_open_grows, clk, rst_n, cmd.open_page && free_found,
        olen_reg == $past(olen_reg) + CW'(1), "page open lost")

endmodule

FILE: hdl/sba_controller.sv
`timescale 1ns / 1ps
`include "small_block_first_fit_allocator_macros.svh"

module sba_controller (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             enable,
    input  sba_pkg::stat_t   stat,
    output sba_pkg::cmd_t    cmd,
    output logic             busy
);

    sba_pkg::state_t state_reg, state_next;
    logic opened_reg, opened_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sba_pkg::S_IDLE;
            opened_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            opened_reg <= opened_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        opened_next = opened_reg;
        cmd         = '0;
        unique case (state_reg)
            sba_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_req = 1'b1;
                    opened_next  = 1'b0;
                    state_next   = sba_pkg::S_DECODE;
                end
            end
            sba_pkg::S_DECODE:
            begin
                if (stat.op == sba_pkg::OP_UNUSED)
                    state_next = sba_pkg::S_IDLE;
                else if (!enable)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = sba_pkg::ST_DISABLED;
                    state_next     = sba_pkg::S_DONE;
                end
                else if (stat.op == sba_pkg::OP_ALLOC)
                begin
                    if (stat.size_bad)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = sba_pkg::ST_BAD_SIZE;
                        state_next     = sba_pkg::S_DONE;
                    end
                    else
                        state_next = sba_pkg::S_ORD_RD;
                end
                else if (stat.loc_ok)
                begin
                    cmd.cur_to_first = 1'b1;
                    state_next       = sba_pkg::S_LOC_RD;
                end
                else
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = sba_pkg::ST_NOT_FOUND;
                    state_next     = sba_pkg::S_DONE;
                end
            end
            // next page of the order list
            sba_pkg::S_ORD_RD:
            begin
                if (stat.ord_more)
                begin
                    cmd.ord_rd = 1'b1;
                    state_next = sba_pkg::S_ORD_WAIT;
                end
                else
                    state_next = sba_pkg::S_OPEN;
            end
            sba_pkg::S_ORD_WAIT:
            begin
                cmd.ord_take     = 1'b1;
                cmd.ord_next     = 1'b1;
                cmd.cur_to_first = 1'b1;
                state_next       = sba_pkg::S_HDR_RD;
            end
            // first-fit walk
            sba_pkg::S_HDR_RD:
            begin
                if (stat.cur_end)
                    state_next = opened_reg ? sba_pkg::S_DONE : sba_pkg::S_ORD_RD;
                else
                begin
                    cmd.hdr_rd_cur = 1'b1;
                    state_next     = sba_pkg::S_HDR_WAIT;
                end
                if (stat.cur_end && opened_reg)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = sba_pkg::ST_NO_SPACE;
                end
            end
            sba_pkg::S_HDR_WAIT:
            begin
                cmd.hdr_latch = 1'b1;
                state_next    = sba_pkg::S_HDR_EVAL;
            end
            sba_pkg::S_HDR_EVAL:
            begin
                if (stat.hdr_bad)
                begin
                    if (opened_reg)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = sba_pkg::ST_NO_SPACE;
                        state_next     = sba_pkg::S_DONE;
                    end
                    else
                        state_next = sba_pkg::S_ORD_RD;
                end
                else if (stat.hdr_fit)
                    state_next = sba_pkg::S_SPLIT;
                else
                begin
                    cmd.cur_advance = 1'b1;
                    state_next      = sba_pkg::S_HDR_RD;
                end
            end
            sba_pkg::S_OPEN:
            begin
                if (stat.can_open)
                begin
                    cmd.open_page    = 1'b1;
                    cmd.cur_to_first = 1'b1;
                    opened_next      = 1'b1;
                    state_next       = sba_pkg::S_HDR_RD;
                end
                else
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = sba_pkg::ST_NO_SPACE;
                    state_next     = sba_pkg::S_DONE;
                end
            end
            // remainder header if split, then the block (span shrinks on a split)
            sba_pkg::S_SPLIT:
            begin
                cmd.split_wr = 1'b1;
                if (stat.hdr_fit && !stat.hdr_free)
                    state_next = sba_pkg::S_DONE;
                else
                    state_next = sba_pkg::S_MARK_FREE;
            end
            sba_pkg::S_MARK_FREE:
            begin
                // second split pass for an allocate, writing the block
                if (stat.op == sba_pkg::OP_ALLOC)
                begin
                    cmd.split_wr  = 1'b1;
                    cmd.set_found = 1'b1;
                    state_next    = sba_pkg::S_DONE;
                end
                else
                begin
                    cmd.free_wr = 1'b1;
                    if (stat.live_last)
                    begin
                        cmd.rel_start = 1'b1;
                        state_next    = sba_pkg::S_REL;
                    end
                    else
                    begin
                        cmd.cur_to_first = 1'b1;
                        state_next       = sba_pkg::S_MRG_RD;
                    end
                end
            end
            // locate the block for free or query
            sba_pkg::S_LOC_RD:
            begin
                if (stat.cur_end)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = sba_pkg::ST_NOT_FOUND;
                    state_next     = sba_pkg::S_DONE;
                end
                else
                begin
                    cmd.hdr_rd_cur = 1'b1;
                    state_next     = sba_pkg::S_LOC_WAIT;
                end
            end
            sba_pkg::S_LOC_WAIT:
            begin
                cmd.hdr_latch = 1'b1;
                state_next    = sba_pkg::S_LOC_EVAL;
            end
            sba_pkg::S_LOC_EVAL:
            begin
                if (stat.hdr_bad || (stat.at_target && stat.hdr_free))
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = sba_pkg::ST_NOT_FOUND;
                    state_next     = sba_pkg::S_DONE;
                end
                else if (stat.at_target)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = (stat.op == sba_pkg::OP_FREE) ? sba_pkg::S_MARK_FREE
                                                                 : sba_pkg::S_DONE;
                end
                else
                begin
                    cmd.cur_advance = 1'b1;
                    state_next      = sba_pkg::S_LOC_RD;
                end
            end
            // drop the page from the order list
            sba_pkg::S_REL:
            begin
                if (stat.rel_more)
                begin
                    cmd.ord_rd = 1'b1;
                    state_next = sba_pkg::S_REL_WAIT;
                end
                else
                begin
                    cmd.rel_finish = 1'b1;
                    state_next     = sba_pkg::S_REL_MOVE;
                end
            end
            sba_pkg::S_REL_WAIT:
            begin
                cmd.rel_step = 1'b1;
                state_next   = sba_pkg::S_REL;
            end
            sba_pkg::S_REL_MOVE:
                state_next = sba_pkg::S_DONE;
            // coalesce free neighbors
            sba_pkg::S_MRG_RD:
            begin
                if (stat.cur_end)
                    state_next = sba_pkg::S_DONE;
                else
                begin
                    cmd.hdr_rd_cur = 1'b1;
                    state_next     = sba_pkg::S_MRG_WAIT;
                end
            end
            sba_pkg::S_MRG_WAIT:
            begin
                cmd.hdr_latch = 1'b1;
                state_next    = sba_pkg::S_MRG_EVAL;
            end
            sba_pkg::S_MRG_EVAL:
            begin
                if (stat.hdr_bad || stat.nxt_end)
                    state_next = sba_pkg::S_DONE;
                else
                    state_next = sba_pkg::S_MRG_NRD;
            end
            sba_pkg::S_MRG_NRD:
            begin
                cmd.hdr_rd_nxt = 1'b1;
                state_next     = sba_pkg::S_MRG_NWAIT;
            end
            sba_pkg::S_MRG_NWAIT:
            begin
                cmd.nxt_latch = 1'b1;
                state_next    = sba_pkg::S_MRG_NEVAL;
            end
            sba_pkg::S_MRG_NEVAL:
            begin
                if (stat.nxt_bad)
                    state_next = sba_pkg::S_DONE;
                else if (stat.hdr_free && stat.nxt_free)
                begin
                    cmd.merge_wr = 1'b1;
                    state_next   = sba_pkg::S_MRG_EVAL;
                end
                else
                begin
                    cmd.cur_advance = 1'b1;
                    state_next      = sba_pkg::S_MRG_RD;
                end
            end
            sba_pkg::S_DONE:
            begin
                cmd.emit   = 1'b1;
                state_next = sba_pkg::S_IDLE;
            end
            default:
                state_next = sba_pkg::S_IDLE;
        endcase
    end

    assign busy = state_reg != sba_pkg::S_IDLE;

    `SBA_ASSERT_NEXT(a_start_taken, clk, rst_n, start && !busy,
        state_reg == sba_pkg::S_DECODE, "request not taken")
    `SBA_ASSERT_NEXT(a_done_idle, clk, rst_n, state_reg == sba_pkg::S_DONE,
        state_reg == sba_pkg::S_IDLE, "result state not left")
    `SBA_ASSERT(a_one_write, clk, rst_n,
        $countones({cmd.split_wr, cmd.free_wr, cmd.merge_wr, cmd.open_page}) <= 1,
        "header write conflict")

endmodule
